// ===== design/cmbunr_pkg.sv =====
// Package for the combination unranking block.
// Holds the request/response payload types, field widths and code constants.
// No dependencies.
`default_nettype none

package cmbunr_pkg;

    // Field widths
    localparam int CNT_W = 7;
    localparam int BIN_W = 30;

    // Binomial counts clip at this value
    localparam logic [BIN_W-1:0] BIN_SAT = 30'd1000001000;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;

    // Symbol codes
    localparam logic SYM_DASH = 1'b0;
    localparam logic SYM_DOT  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] dash_count;
        logic [CNT_W-1:0] dot_count;
        logic [BIN_W-1:0] rank;
    } t_req;

    typedef struct packed {
        logic       symbol;
        logic       last;
        logic [1:0] status;
    } t_rsp;

endpackage

`default_nettype wire

// ===== design/cmbunr_if.sv =====
// Valid/ready channel interfaces for the combination unranking block.
// Depends on cmbunr_pkg for the payload types.
`default_nettype none

interface cmbunr_req_if;
    import cmbunr_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cmbunr_rsp_if;
    import cmbunr_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cmbunr_binom.sv =====
// Saturated Pascal triangle store with its build sequencer.
// Builds all rows after reset, then serves one registered read per cycle.
// Depends on cmbunr_pkg.
`default_nettype none

module cmbunr_binom #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_rd_en,
    input  wire logic [$clog2((MAX_LEN+1)*(MAX_LEN+1))-1:0]        i_rd_addr,
    output logic      [cmbunr_pkg::BIN_W-1:0]                      o_rd_data,
    output logic                                                   o_ready
);
    import cmbunr_pkg::*;

    localparam int DIM   = MAX_LEN + 1;
    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(DIM);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_LEN);

    logic [BIN_W-1:0] r_mem [DEPTH];

    // build counters (issue stage)
    logic          r_fill_busy;
    logic [IW-1:0] r_fill_i;
    logic [IW-1:0] r_fill_j;
    logic [AW-1:0] r_fill_addr;

    // write stage
    logic          r_wr_valid;
    logic          r_wr_row0;
    logic          r_wr_j0;
    logic [AW-1:0] r_wr_addr;
    logic [BIN_W-1:0] r_left;
    logic [BIN_W-1:0] r_rd_data;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [BIN_W:0] n_sum;
    logic [BIN_W-1:0] n_wr_data;

    // Read port: row above during build, caller afterwards
    always_comb begin
        if (r_fill_busy) begin
            rd_en   = (r_fill_i != '0);
            rd_addr = r_fill_addr - AW'(DIM);
        end else begin
            rd_en   = i_rd_en;
            rd_addr = i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Build sequencer: one entry per cycle, row by row, full rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_busy <= 1'b1;
            r_fill_i    <= '0;
            r_fill_j    <= '0;
            r_fill_addr <= '0;
            r_wr_valid  <= 1'b0;
        end else begin
            r_wr_valid <= r_fill_busy;
            if (r_fill_busy) begin
                r_fill_addr <= r_fill_addr + AW'(1);
                if (r_fill_j == LAST_IDX) begin
                    r_fill_j <= '0;
                    r_fill_i <= r_fill_i + IW'(1);
                    if (r_fill_i == LAST_IDX) begin
                        r_fill_busy <= 1'b0;
                    end
                end else begin
                    r_fill_j <= r_fill_j + IW'(1);
                end
            end
        end
    end

    // Write-stage tags
    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_fill_addr;
        r_wr_row0 <= (r_fill_i == '0);
        r_wr_j0   <= (r_fill_j == '0);
        if (r_wr_valid) begin
            r_left <= r_rd_data;
        end
    end

    // C(i,j) = C(i-1,j-1) + C(i-1,j), clipped; edge of triangle is 1
    always_comb begin
        n_sum = {1'b0, r_left} + {1'b0, r_rd_data};
        if (r_wr_j0) begin
            n_wr_data = BIN_W'(1);
        end else if (r_wr_row0) begin
            n_wr_data = '0;
        end else if (n_sum > {1'b0, BIN_SAT}) begin
            n_wr_data = BIN_SAT;
        end else begin
            n_wr_data = n_sum[BIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wr_valid) begin
            r_mem[r_wr_addr] <= n_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_fill_busy && !r_wr_valid;

endmodule

`default_nettype wire

// ===== design/combination_unrank.sv =====
// Lexicographic combination unranking: top level with the symbol sequencer.
// Depends on cmbunr_pkg, cmbunr_if and cmbunr_binom.
//
// Usage:
//   i_req carries a dash count, a dot count and a one-based rank. o_rsp returns
//   the selected string one symbol per response (0 dash, 1 dot), the final one
//   flagged by last. A request whose total length is zero or above MAX_LEN
//   yields one status-only response instead.
// Timing:
//   After reset the binomial table is built, one entry per cycle, and
//   i_req.ready is low meanwhile. An accepted request is registered, the
//   first table entry is read in S_PREP, then S_RUN emits one symbol per
//   cycle while the output register is free. Each symbol needs one table read
//   and one compare/subtract on the remaining rank, and the read for the next
//   symbol is issued in the same cycle. A status-only request skips S_PREP
//   and S_RUN and answers from S_STAT. Every response leaves through the
//   output register.
// Stalls:
//   Responses sit in a single output register; while it is full and not taken
//   the sequencer holds in S_RUN and S_STAT, and so does the registered table read.
`default_nettype none

module combination_unrank #(
    parameter int MAX_LEN = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cmbunr_req_if.sink   i_req,
    cmbunr_rsp_if.source o_rsp
);
    import cmbunr_pkg::*;

    localparam int DIM   = MAX_LEN + 1;
    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_RUN  = 4'b0100,
        S_STAT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_dashes, n_dashes;
    logic [CNT_W-1:0] r_dots, n_dots;
    logic [BIN_W-1:0] r_skip, n_skip;
    logic [AW-1:0]    r_addr, n_addr;
    logic [1:0]       r_stat, n_stat;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic             tbl_rd_en;
    logic [AW-1:0]    tbl_rd_addr;
    logic [BIN_W-1:0] tbl_data;
    logic             tbl_ready;

    logic             req_fire;
    logic             slot_free;
    logic [CNT_W:0]   in_total;
    logic [AW-1:0]    a_dot;
    logic             take_dot;
    logic             run_last;
    logic             both_left;

    cmbunr_binom #(
        .MAX_LEN (MAX_LEN)
    ) u_binom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_data (tbl_data),
        .o_ready   (tbl_ready)
    );

    assign i_req.ready = (r_state == S_IDLE) && tbl_ready;
    assign req_fire    = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Per-symbol decision against the completions that start with a dash
    assign in_total  = {1'b0, i_req.data.dash_count} + {1'b0, i_req.data.dot_count};
    assign both_left = (r_dashes != '0) && (r_dots != '0);
    assign run_last  = ({1'b0, r_dashes} + {1'b0, r_dots}) == (CNT_W+1)'(1);
    assign a_dot     = r_addr - AW'(DIM);

    always_comb begin
        if (r_dashes == '0) begin
            take_dot = 1'b1;
        end else if (r_dots == '0) begin
            take_dot = 1'b0;
        end else begin
            take_dot = !(r_skip < tbl_data);
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_dashes    = r_dashes;
        n_dots      = r_dots;
        n_skip      = r_skip;
        n_addr      = r_addr;
        n_stat      = r_stat;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = r_addr;

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_dashes = i_req.data.dash_count;
                    n_dots   = i_req.data.dot_count;
                    n_skip   = (i_req.data.rank == '0) ? '0
                                                       : i_req.data.rank - BIN_W'(1);
                    // entry of C(total-1, dashes-1)
                    n_addr   = AW'(in_total - (CNT_W+1)'(1)) * AW'(DIM)
                             + AW'(i_req.data.dash_count - CNT_W'(1));
                    if (in_total == '0) begin
                        n_stat  = ST_EMPTY;
                        n_state = S_STAT;
                    end else if (in_total > (CNT_W+1)'(MAX_LEN)) begin
                        n_stat  = ST_LONG;
                        n_state = S_STAT;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                tbl_rd_en = both_left;
                n_state   = S_RUN;
            end
            S_RUN: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out.symbol = take_dot ? SYM_DOT : SYM_DASH;
                    n_out.last   = run_last;
                    n_out.status = ST_OK;
                    if (take_dot) begin
                        n_dots = r_dots - CNT_W'(1);
                        n_addr = a_dot;
                        if (both_left) begin
                            n_skip = r_skip - tbl_data;
                        end
                    end else begin
                        n_dashes = r_dashes - CNT_W'(1);
                        n_addr   = a_dot - AW'(1);
                    end
                    // fetch the next count while this symbol goes out
                    tbl_rd_en   = (n_dashes != '0) && (n_dots != '0);
                    tbl_rd_addr = n_addr;
                    if (run_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_STAT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out.symbol = SYM_DASH;
                    n_out.last   = 1'b1;
                    n_out.status = r_stat;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_dashes <= n_dashes;
        r_dots   <= n_dots;
        r_skip   <= n_skip;
        r_addr   <= n_addr;
        r_stat   <= n_stat;
        r_out    <= n_out;
    end

    // Checks
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> (r_dashes != '0 || r_dots != '0))
        else $error("sequencer running with no symbols left");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && slot_free && run_last |=> r_state == S_IDLE && r_out.last)
        else $error("final symbol did not end the request");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_OK |-> r_out.last)
        else $error("status response not flagged last");

    a_table_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> tbl_ready)
        else $error("request in flight while table is being built");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && both_left |-> r_addr < AW'(DEPTH))
        else $error("table address out of range");

endmodule

`default_nettype wire

// ===== tb/tb_combination_unrank.sv =====
// Testbench for combination_unrank: random and directed unranking requests,
// with a scoreboard that predicts each response symbol from its own Pascal triangle.
// Depends on cmbunr_pkg, cmbunr_if and the combination_unrank RTL.
`default_nettype none

module tb_combination_unrank;
    timeunit 1ns;
    timeprecision 1ps;

    import cmbunr_pkg::*;

    localparam int MAX_LEN    = 64;
    localparam int IDLE_PCT   = 37;
    localparam int TAIL_WAIT  = 70;
    localparam int CYCLE_CAP  = 400000;

    // Predicts response symbols and checks them in order of arrival
    class unrank_scoreboard;
        logic [BIN_W-1:0] pascal [0:MAX_LEN][0:MAX_LEN];
        t_rsp             symbols_due [$];
        int               errors;

        function new();
            logic [BIN_W:0] sum;
            errors = 0;
            for (int i = 0; i <= MAX_LEN; i++) begin
                for (int j = 0; j <= MAX_LEN; j++) begin
                    pascal[i][j] = '0;
                end
            end
            // Saturated binomials, zero above the diagonal
            for (int i = 0; i <= MAX_LEN; i++) begin
                pascal[i][0] = BIN_W'(1);
                pascal[i][i] = BIN_W'(1);
                for (int j = 1; j < i; j++) begin
                    sum = {1'b0, pascal[i-1][j-1]} + {1'b0, pascal[i-1][j]};
                    pascal[i][j] = (sum > {1'b0, BIN_SAT}) ? BIN_SAT : sum[BIN_W-1:0];
                end
            end
        endfunction

        function void note_request(t_req req);
            int unsigned      dashes;
            int unsigned      dots;
            logic [BIN_W-1:0] skip;
            logic [BIN_W-1:0] lead;
            t_rsp             rsp;
            dashes = 32'(req.dash_count);
            dots   = 32'(req.dot_count);
            skip   = (req.rank == '0) ? '0 : req.rank - BIN_W'(1);
            rsp.symbol = SYM_DASH;
            rsp.last   = 1'b1;
            // Status-only responses
            if (dashes + dots == 0) begin
                rsp.status = ST_EMPTY;
                symbols_due.push_back(rsp);
                return;
            end
            if (dashes + dots > MAX_LEN) begin
                rsp.status = ST_LONG;
                symbols_due.push_back(rsp);
                return;
            end
            // One symbol per position, dash if the rank falls among dash-led completions
            rsp.status = ST_OK;
            while (dashes + dots > 0) begin
                if (dashes == 0) begin
                    rsp.symbol = SYM_DOT;
                end else if (dots == 0) begin
                    rsp.symbol = SYM_DASH;
                end else begin
                    lead = pascal[dashes + dots - 1][dashes - 1];
                    if (skip < lead) begin
                        rsp.symbol = SYM_DASH;
                    end else begin
                        skip       = skip - lead;
                        rsp.symbol = SYM_DOT;
                    end
                end
                if (rsp.symbol == SYM_DASH) dashes--;
                else dots--;
                rsp.last = (dashes + dots == 0);
                symbols_due.push_back(rsp);
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (symbols_due.size() == 0) begin
                $error("response with nothing expected: symbol %0d last %0d status %0d",
                       got.symbol, got.last, got.status);
                errors++;
                return;
            end
            want = symbols_due.pop_front();
            if (got.symbol !== want.symbol) begin
                $error("symbol: expected %0d, actual %0d", want.symbol, got.symbol);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return symbols_due.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   cycle_count;

    unrank_scoreboard sb;

    cmbunr_req_if req_if();
    cmbunr_rsp_if rsp_if();

    combination_unrank #(
        .MAX_LEN (MAX_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Response backpressure, changed on the falling edge
    always @(negedge i_clk) begin
        rsp_if.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) sb.note_request(req_if.data);
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    end

    // Present one request, with random idle cycles ahead of it; returns on a falling edge
    task automatic send_request(input t_req req);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = req;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input int unsigned dashes, input int unsigned dots,
                               input logic [BIN_W-1:0] rank);
        t_req req;
        req.dash_count = CNT_W'(dashes);
        req.dot_count  = CNT_W'(dots);
        req.rank       = rank;
        send_request(req);
    endtask

    // Mostly well-formed requests with in-range ranks; some beyond, zero or pure noise
    task automatic send_random();
        int unsigned      pick;
        int unsigned      len;
        int unsigned      dashes;
        logic [BIN_W-1:0] total;
        logic [BIN_W-1:0] rank;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_fields($urandom_range(0, 127), $urandom_range(0, 127), BIN_W'($urandom()));
        end else begin
            len    = (pick < 65) ? $urandom_range(1, 12) : $urandom_range(1, MAX_LEN);
            dashes = $urandom_range(0, len);
            total  = sb.pascal[len][dashes];
            if (pick < 15) rank = total + BIN_W'($urandom_range(1, 1000));
            else if (pick < 18) rank = '0;
            else rank = BIN_W'($urandom_range(1, 32'(total)));
            send_fields(dashes, len - dashes, rank);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        sb            = new();
        calm          = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty, too long, first/last/beyond rank, rank zero, one kind only
        send_fields(0, 0, 1);
        send_fields(0, 0, 30'h3FFFFFFF);
        send_fields(64, 0, 1);
        send_fields(0, 64, 1);
        send_fields(1, 64, 5);
        send_fields(64, 64, 30'h3FFFFFFF);
        send_fields(127, 127, 30'h2AAAAAAA);
        send_fields(127, 0, 1);
        send_fields(3, 2, 1);
        send_fields(3, 2, 10);
        send_fields(3, 2, 11);
        send_fields(3, 2, 0);
        send_fields(1, 1, 2);
        send_fields(5, 0, 7);
        send_fields(0, 5, 3);
        send_fields(1, 0, 1);
        send_fields(0, 1, 1);
        send_fields(63, 1, 64);
        send_fields(32, 32, 1000000000);
        send_fields(32, 32, 30'h3FFFFFFF);
        send_fields(40, 24, 30'h15555555);
        send_fields(2, 62, 2016);

        // Random, with a drain pause and a stretch without idling
        for (int i = 0; i < 50; i++) send_random();
        req_if.valid = 1'b0;
        wait_drained();
        calm = 1'b1;
        for (int i = 0; i < 40; i++) send_random();
        calm = 1'b0;
        for (int i = 0; i < 50; i++) send_random();
        req_if.valid = 1'b0;

        wait_drained();
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
